[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the chain energy block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define AST_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// consequence that must hold in the cycle after the antecedent
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_HOLDS(label, expr)
`define AST_NEXT(label, ante, cons)
`endif
`endif

[sv/dclj_pkg.sv]
// ---------------------------------------------------------------------------
// dclj_pkg
// shared widths, register indexes and controller/datapath interface types
// ---------------------------------------------------------------------------
package dclj_pkg;

  localparam int POS_BITS   = 32;
  localparam int DIST_BITS  = 32;
  localparam int NUM_BITS   = 224;
  localparam int E_BITS     = 48;
  localparam int COEF_BITS  = 32;
  localparam int CELL_BITS  = 16;
  localparam int SITE_BITS  = 17;
  localparam int BIT_CNT_W  = 8;
  localparam int PASS_CNT_W = 4;
  localparam int ATT_PASSES = 6;
  localparam int REP_PASSES = 12;
  localparam int ATT_SHIFT  = 96;
  localparam int REP_SHIFT  = 192;

  localparam logic signed [E_BITS-1:0] E_MAX = {1'b0, {(E_BITS-1){1'b1}}};
  localparam logic signed [E_BITS-1:0] E_MIN = {1'b1, {(E_BITS-1){1'b0}}};

  // register indexes
  localparam logic [2:0] CFG_REP_EVEN = 3'd0;
  localparam logic [2:0] CFG_ATT_EVEN = 3'd1;
  localparam logic [2:0] CFG_REP_ODD  = 3'd2;
  localparam logic [2:0] CFG_ATT_ODD  = 3'd3;
  localparam logic [2:0] CFG_CELLS    = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic capture_first;
    logic start_bond;
    logic odd_bond;
    logic step;
    logic last_bit;
    logic load_rep;
    logic accumulate;
    logic emit;
  } dclj_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic                 dist_zero;
    logic [CELL_BITS-1:0] cells;
  } dclj_stat_t;

endpackage

[sv/dclj_dp.sv]
// ---------------------------------------------------------------------------
// dclj_dp
// datapath: config registers, bond distance, serial divider, accumulator
// ---------------------------------------------------------------------------
module dclj_dp import dclj_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [COEF_BITS-1:0]        cfg_wdata,
  input  logic signed [POS_BITS-1:0]  in_position,
  input  dclj_cmd_t                   cmd,
  output dclj_stat_t                  stat,
  output logic signed [E_BITS-1:0]    out_energy,
  output logic                        out_saturated
);

  logic [COEF_BITS-1:0]       rep_even_r, att_even_r, rep_odd_r, att_odd_r;
  logic [CELL_BITS-1:0]       cells_r;
  logic signed [POS_BITS-1:0] prev_r;
  logic [DIST_BITS-1:0]       dist_r;
  logic [NUM_BITS-1:0]        num_r;
  logic [DIST_BITS-1:0]       rem_r;
  logic [COEF_BITS-1:0]       rep_sel_r;
  logic [E_BITS-1:0]          att_q_r;
  logic                       att_sat_r;
  logic                       zero_r;
  logic signed [E_BITS-1:0]   acc_r;
  logic                       sticky_r;
  logic signed [E_BITS-1:0]   out_energy_r;
  logic                       out_sat_r;

  logic signed [POS_BITS:0]   diff;
  logic [DIST_BITS-1:0]       dist_in;
  logic [DIST_BITS:0]         rem_sh;
  logic                       ge;
  logic [DIST_BITS:0]         rem_sub;
  logic                       rep_sat;
  logic signed [E_BITS:0]     quot_diff;
  logic signed [E_BITS:0]     term;
  logic                       term_flag;
  logic signed [E_BITS:0]     sum;
  logic signed [E_BITS-1:0]   sum_clip;
  logic                       sum_flag;

  // distance of the incoming site from the previous one
  always_comb begin
    diff    = {in_position[POS_BITS-1], in_position} - {prev_r[POS_BITS-1], prev_r};
    dist_in = diff[POS_BITS] ? DIST_BITS'(-diff) : DIST_BITS'(diff);
  end

  // one restoring division step by the distance
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_BITS-1]};
    ge      = rem_sh >= {1'b0, dist_r};
    rem_sub = rem_sh - {1'b0, dist_r};
  end

  // bond term and saturating running sum
  always_comb begin
    rep_sat   = |num_r[NUM_BITS-1:E_BITS];
    quot_diff = $signed({1'b0, num_r[E_BITS-1:0]}) - $signed({1'b0, att_q_r});
    if (zero_r || rep_sat) begin
      term      = {E_MAX[E_BITS-1], E_MAX};
      term_flag = 1'b1;
    end else if (att_sat_r) begin
      term      = {E_MIN[E_BITS-1], E_MIN};
      term_flag = 1'b1;
    end else if (quot_diff > $signed({E_MAX[E_BITS-1], E_MAX})) begin
      term      = {E_MAX[E_BITS-1], E_MAX};
      term_flag = 1'b1;
    end else if (quot_diff < $signed({E_MIN[E_BITS-1], E_MIN})) begin
      term      = {E_MIN[E_BITS-1], E_MIN};
      term_flag = 1'b1;
    end else begin
      term      = quot_diff;
      term_flag = 1'b0;
    end
    sum = {acc_r[E_BITS-1], acc_r} + term;
    if (sum[E_BITS] != sum[E_BITS-1]) begin
      sum_clip = sum[E_BITS] ? E_MIN : E_MAX;
      sum_flag = 1'b1;
    end else begin
      sum_clip = sum[E_BITS-1:0];
      sum_flag = 1'b0;
    end
  end

  // configuration and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_even_r <= '0;
      att_even_r <= '0;
      rep_odd_r  <= '0;
      att_odd_r  <= '0;
      cells_r    <= CELL_BITS'(1);
      prev_r     <= '0;
      acc_r      <= '0;
      sticky_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REP_EVEN: rep_even_r <= cfg_wdata;
          CFG_ATT_EVEN: att_even_r <= cfg_wdata;
          CFG_REP_ODD:  rep_odd_r  <= cfg_wdata;
          CFG_ATT_ODD:  att_odd_r  <= cfg_wdata;
          CFG_CELLS:    cells_r    <= cfg_wdata[CELL_BITS-1:0];
          default:      ;
        endcase
      end
      if (cmd.capture_first || cmd.start_bond) begin
        prev_r <= in_position;
      end
      if (cmd.accumulate) begin
        acc_r    <= sum_clip;
        sticky_r <= sticky_r | term_flag | sum_flag;
      end else if (cmd.emit) begin
        acc_r    <= '0;
        sticky_r <= 1'b0;
      end
    end
  end

  // divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.start_bond) begin
      dist_r    <= dist_in;
      zero_r    <= (dist_in == '0);
      rep_sel_r <= cmd.odd_bond ? rep_odd_r : rep_even_r;
      num_r     <= NUM_BITS'(cmd.odd_bond ? att_odd_r : att_even_r) << ATT_SHIFT;
      rem_r     <= '0;
    end else if (cmd.load_rep) begin
      att_q_r   <= num_r[E_BITS-1:0];
      att_sat_r <= |num_r[NUM_BITS-1:E_BITS];
      num_r     <= NUM_BITS'(rep_sel_r) << REP_SHIFT;
      rem_r     <= '0;
    end else if (cmd.step) begin
      num_r <= {num_r[NUM_BITS-2:0], ge};
      if (cmd.last_bit) begin
        rem_r <= '0;
      end else begin
        rem_r <= ge ? rem_sub[DIST_BITS-1:0] : rem_sh[DIST_BITS-1:0];
      end
    end
    if (cmd.emit) begin
      out_energy_r <= acc_r;
      out_sat_r    <= sticky_r;
    end
  end

  assign stat.dist_zero = (dist_in == '0);
  assign stat.cells     = cells_r;
  assign out_energy     = out_energy_r;
  assign out_saturated  = out_sat_r;

endmodule

[sv/dclj_ctrl.sv]
// ---------------------------------------------------------------------------
// dclj_ctrl
// controller: site counting, division pass sequencing, result hand-off
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module dclj_ctrl import dclj_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dclj_stat_t stat,
  output dclj_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_ATT, S_LOAD_REP, S_DIV_REP, S_ACC, S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [SITE_BITS-1:0]  site_r, site_nxt;
  logic [BIT_CNT_W-1:0]  bit_r, bit_nxt;
  logic [PASS_CNT_W-1:0] pass_r, pass_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  accept;
  logic                  last_bit;
  logic [CELL_BITS-1:0]  cells_eff;
  logic [SITE_BITS-1:0]  site_inc;
  logic                  chain_done;
  logic                  slot_free;

  always_comb begin
    accept     = in_valid && !in_stall;
    last_bit   = (bit_r == BIT_CNT_W'(NUM_BITS - 1));
    cells_eff  = (stat.cells == '0) ? CELL_BITS'(1) : stat.cells;
    site_inc   = site_r + SITE_BITS'(1);
    chain_done = site_inc >= {cells_eff, 1'b0};
    slot_free  = !out_valid_r || !out_stall;
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    site_nxt      = site_r;
    bit_nxt       = bit_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.odd_bond  = site_r[0] == 1'b0;
    cmd.last_bit  = last_bit;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (site_r == '0) begin
            cmd.capture_first = 1'b1;
            site_nxt          = SITE_BITS'(1);
          end else begin
            cmd.start_bond = 1'b1;
            bit_nxt        = '0;
            pass_nxt       = '0;
            state_nxt      = stat.dist_zero ? S_ACC : S_DIV_ATT;
          end
        end
      end
      S_DIV_ATT: begin
        cmd.step = 1'b1;
        bit_nxt  = bit_r + BIT_CNT_W'(1);
        if (last_bit) begin
          bit_nxt  = '0;
          pass_nxt = pass_r + PASS_CNT_W'(1);
          if (pass_r == PASS_CNT_W'(ATT_PASSES - 1)) begin
            state_nxt = S_LOAD_REP;
          end
        end
      end
      S_LOAD_REP: begin
        cmd.load_rep = 1'b1;
        pass_nxt     = '0;
        bit_nxt      = '0;
        state_nxt    = S_DIV_REP;
      end
      S_DIV_REP: begin
        cmd.step = 1'b1;
        bit_nxt  = bit_r + BIT_CNT_W'(1);
        if (last_bit) begin
          bit_nxt  = '0;
          pass_nxt = pass_r + PASS_CNT_W'(1);
          if (pass_r == PASS_CNT_W'(REP_PASSES - 1)) begin
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        site_nxt       = site_inc;
        state_nxt      = chain_done ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          site_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      site_r      <= '0;
      bit_r       <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      site_r      <= site_nxt;
      bit_r       <= bit_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `AST_HOLDS(a_att_pass_range, (state_r != S_DIV_ATT) || (pass_r < PASS_CNT_W'(ATT_PASSES)))
  `AST_NEXT(a_bond_starts, accept && (site_r != '0) && !stat.dist_zero, state_r == S_DIV_ATT)
  `AST_NEXT(a_emit_shows, (state_r == S_EMIT) && slot_free, out_valid_r && (site_r == '0))

endmodule

[sv/dimer_chain_lj_energy_sum.sv]
// ---------------------------------------------------------------------------
// dimer_chain_lj_energy_sum
// 12-6 pair potential summed over a two-bond-type chain of site positions
// ---------------------------------------------------------------------------
// Sites stream in on the in_ request (valid/stall), one signed Q16.16 position
// each. The first site of a chain is only stored. Every later site closes a
// bond: its term needs six restoring-division passes (attractive part) and
// twelve (repulsive part) of 224 quotient bits each through one shared
// one-bit-per-cycle divider, plus a load and an accumulate step, all with
// in_stall high; a zero-length bond skips the divider and only accumulates.
// in_stall is high while a bond is in work or a result waits to be emitted.
// After site 2*cell_count the total energy and the sticky saturation flag go
// into an output register from the emit state after the last bond, or later
// while a previous result is still held by out_stall; the next chain's first
// site may be taken while a result waits. The user must write coefficients
// and cell_count through cfg_ only while idle; the block itself does not
// enforce it. Reset (rst_n low, synchronous) clears the chain state, drops
// out_valid and sets all coefficients to zero and cell_count to one.
// ---------------------------------------------------------------------------
module dimer_chain_lj_energy_sum import dclj_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [COEF_BITS-1:0]       cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [POS_BITS-1:0] in_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [E_BITS-1:0]   out_energy,
  output logic                       out_saturated
);

  dclj_cmd_t  cmd;
  dclj_stat_t stat;

  // sequencing
  dclj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic
  dclj_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_position   (in_position),
    .cmd           (cmd),
    .stat          (stat),
    .out_energy    (out_energy),
    .out_saturated (out_saturated)
  );

endmodule

[test/tb.sv]
// ---------------------------------------------------------------------------
// chain energy testbench
// streams site positions into the 12-6 chain energy block and checks each
// emitted total against a bit-exact wide-integer prediction of the bond sums
// ---------------------------------------------------------------------------
module tb import dclj_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int BOND_CYCLES    = 4100;
  localparam int SITE_TARGET    = 1850;

  // index with no register behind it
  localparam logic [2:0] CFG_UNUSED = 3'd6;

  typedef struct {
    logic signed [E_BITS-1:0] energy;
    logic                     saturated;
  } chain_total_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [2:0]                 cfg_index;
  logic [COEF_BITS-1:0]       cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [POS_BITS-1:0] in_position;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [E_BITS-1:0]   out_energy;
  logic                       out_saturated;

  // predictor state
  logic [COEF_BITS-1:0]       rep_even, att_even, rep_odd, att_odd;
  logic [CELL_BITS-1:0]       cells;
  logic signed [POS_BITS-1:0] prev_site;
  int unsigned                site_idx;
  logic signed [E_BITS-1:0]   energy_sum;
  logic                       sat_sticky;

  chain_total_t               totals_q[$];
  int                         mismatches;
  int                         sites_sent;
  int                         idle_cycles;
  logic signed [POS_BITS-1:0] last_pos;
  int                         stall_run;

  dimer_chain_lj_energy_sum dut (.*);

  // clock
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // one bond term, exact integer quotients, clamped to 48 bits
  function automatic logic signed [E_BITS-1:0] bond_energy(
      input logic [33:0] bond_len, input logic [31:0] rep, input logic [31:0] att,
      inout logic flag);
    logic [447:0] d, d6, d12, nr, na, r, a;
    logic signed [49:0] diff;
    if (bond_len == 0) begin
      flag = 1'b1;
      return E_MAX;
    end
    if (bond_len >= (34'd1 << 33)) return '0;
    d   = bond_len;
    d6  = d * d * d * d * d * d;
    d12 = d6 * d6;
    nr  = {416'd0, rep} << 192;
    na  = {416'd0, att} << 96;
    r   = nr / d12;
    a   = na / d6;
    if (r >= (448'd1 << 48)) begin
      flag = 1'b1;
      return E_MAX;
    end
    if (a >= (448'd1 << 48)) begin
      flag = 1'b1;
      return E_MIN;
    end
    diff = $signed({2'b00, r[47:0]}) - $signed({2'b00, a[47:0]});
    if (diff > $signed({2'b00, E_MAX})) begin
      flag = 1'b1;
      return E_MAX;
    end
    if (diff < -$signed(50'd1 << 47)) begin
      flag = 1'b1;
      return E_MIN;
    end
    return diff[E_BITS-1:0];
  endfunction

  // advance the chain model by one accepted site
  task automatic take_site(input logic signed [POS_BITS-1:0] pos);
    logic signed [33:0]       delta;
    logic [33:0]              bond_len;
    logic signed [E_BITS-1:0] term;
    logic signed [E_BITS:0]   sum;
    logic                     flag;
    int unsigned              n;
    chain_total_t             t;
    n = (cells == 0) ? 1 : cells;
    if (site_idx == 0) begin
      prev_site = pos;
      site_idx  = 1;
      return;
    end
    delta    = $signed({{2{pos[31]}}, pos}) - $signed({{2{prev_site[31]}}, prev_site});
    bond_len = delta[33] ? -delta : delta;
    flag     = sat_sticky;
    if (((site_idx - 1) & 1) == 0) term = bond_energy(bond_len, rep_even, att_even, flag);
    else term = bond_energy(bond_len, rep_odd, att_odd, flag);
    sum = $signed({energy_sum[47], energy_sum}) + $signed({term[47], term});
    if (sum > $signed({1'b0, E_MAX})) begin
      sum = {1'b0, E_MAX};
      flag = 1'b1;
    end
    if (sum < $signed({1'b1, E_MIN})) begin
      sum = {1'b1, E_MIN};
      flag = 1'b1;
    end
    energy_sum = sum[E_BITS-1:0];
    sat_sticky = flag;
    prev_site  = pos;
    site_idx++;
    if (site_idx >= 2 * n) begin
      t.energy    = energy_sum;
      t.saturated = sat_sticky;
      totals_q.push_back(t);
      energy_sum = '0;
      sat_sticky = 1'b0;
      site_idx   = 0;
    end
  endtask

  // input side monitor feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) take_site(in_position);
  end

  // result checker
  always @(posedge clk) begin
    chain_total_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (totals_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: energy=%0d saturated=%0b", out_energy, out_saturated);
      end else begin
        t = totals_q.pop_front();
        if (out_energy !== t.energy || out_saturated !== t.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: energy exp=%0d act=%0d saturated exp=%0b act=%0b",
                     t.energy, out_energy, t.saturated, out_saturated);
        end
      end
    end
  end

  // random output stalls, mostly short bursts
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on request progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one site request with a random lead-in gap
  task automatic send_site(input logic signed [POS_BITS-1:0] pos);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    last_pos = pos;
    sites_sent++;
  endtask

  // let the block go quiet before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (totals_q.size() == 0);
    @(posedge clk);
    repeat (BOND_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [COEF_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_REP_EVEN: rep_even = val;
      CFG_ATT_EVEN: att_even = val;
      CFG_REP_ODD:  rep_odd  = val;
      CFG_ATT_ODD:  att_odd  = val;
      CFG_CELLS:    cells    = val[CELL_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_coefs(input logic [31:0] re, ae, ro, ao);
    write_reg(CFG_REP_EVEN, re);
    write_reg(CFG_ATT_EVEN, ae);
    write_reg(CFG_REP_ODD, ro);
    write_reg(CFG_ATT_ODD, ao);
  endtask

  // reset values: zero coefficients, single cell
  task automatic test_reset_state();
    send_site(32'sh0001_0000);
    send_site(32'sh0002_0000);
    settle();
  endtask

  // zero length, repulsive and attractive overflow, clamps, sum saturation
  task automatic test_bond_cases();
    set_coefs(32'h0100_0000, 32'h0200_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_CELLS, 16'd2);
    send_site(32'sh0000_0000);
    send_site(32'sh0001_0000);
    send_site(32'sh0001_0000);
    send_site(32'sh0001_0100);
    send_site(32'sh7FFF_FFFF);
    send_site(32'sh8000_0000);
    send_site(32'sh8000_0000);
    send_site(32'sh8000_0000);
    settle();
    set_coefs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
    send_site(32'shFFFF_FFFF);
    send_site(32'shFFFF_FFF0);
    send_site(32'sh0000_4000);
    send_site(32'sh0000_8000);
    settle();
    // saturated terms from quotients over the overflow bound
    set_coefs(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_site(32'sh0000_0000);
    send_site(32'sh0000_0200);
    send_site(32'sh0000_0400);
    send_site(32'sh0000_0200);
    settle();
  endtask

  // zero cell count, largest count then lowered mid-chain
  task automatic test_cell_count();
    set_coefs(32'h0100_0000, 32'h0100_0000, 32'h0080_0000, 32'h0300_0000);
    write_reg(CFG_CELLS, 16'd0);
    send_site(32'sh0000_0000);
    send_site(32'sh0001_8000);
    settle();
    write_reg(CFG_CELLS, 16'hFFFF);
    send_site(32'sh0000_0000);
    send_site(32'sh0001_0000);
    send_site(32'sh0002_4000);
    send_site(32'sh0003_0000);
    send_site(32'sh0004_2000);
    settle();
    write_reg(CFG_CELLS, 16'd2);
    send_site(32'sh0005_0000);
    settle();
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0010_0000, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic signed [31:0] next_pos(input logic signed [31:0] p);
    int r;
    logic signed [31:0] step;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom;
    if (r < 12) return p;
    step = (r < 16) ? $urandom_range(1, 32'h800) : $urandom_range(32'h2000, 32'h6_0000);
    return $urandom_range(0, 1) ? p + step : p - step;
  endfunction

  // random chains over a series of random settings
  task automatic test_random_chains();
    int k;
    while (sites_sent < SITE_TARGET) begin
      set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
      write_reg(CFG_CELLS, ($urandom_range(0, 9) == 0) ? 16'd0 : $urandom_range(1, 3));
      for (k = 0; k < 100 && sites_sent < SITE_TARGET; k++) send_site(next_pos(last_pos));
      settle();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_position = '0;
    out_stall   = 1'b0;
    stall_run   = 0;
    idle_cycles = 0;
    mismatches  = 0;
    sites_sent  = 0;
    last_pos    = '0;
    rep_even = '0; att_even = '0; rep_odd = '0; att_odd = '0;
    cells = 16'd1;
    prev_site = '0; site_idx = 0; energy_sum = '0; sat_sticky = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_bond_cases();
    test_cell_count();
    test_random_chains();

    if (mismatches == 0 && totals_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/dclj_pkg.sv
sv/dclj_dp.sv
sv/dclj_ctrl.sv
sv/dimer_chain_lj_energy_sum.sv
test/tb.sv
